>>> rtl/plep_pkg.sv
// ----------------------------------------------------------------------------
// Port list expression parser package
// Shared types, character codes and command codes for the parser core.
// ----------------------------------------------------------------------------
package plep_pkg;

   localparam int MAP_DEPTH = 8192;
   localparam int MAP_AW = $clog2(MAP_DEPTH);
   localparam logic [16:0] PORT_LIMIT = 17'd65536;
   localparam logic [19:0] RADIX = 20'd10;
   localparam logic [2:0] BIT_MASK = 3'd7;

   localparam logic [1:0] OP_REPLACE = 2'd0;
   localparam logic [1:0] OP_EXTEND = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;
   localparam logic [1:0] OP_NONE = 2'd3;

   localparam logic KIND_DONE = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   localparam logic [7:0] CH_NUL = 8'h00;
   localparam logic [7:0] CH_SEP = 8'h2C;
   localparam logic [7:0] CH_DASH = 8'h2D;
   localparam logic [7:0] CH_PLUS = 8'h2B;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_NINE = 8'h39;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] ch;
      logic last;
      logic [15:0] port;
   } req_type;

   typedef struct packed {
      logic kind;
      logic ok;
      logic [15:0] count;
      logic hit;
   } rsp_type;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_SEG_EMPTY,
      PH_LEAD,
      PH_SIGN,
      PH_DIGITS
   } phase_type;

   typedef enum logic [2:0] {
      SC_CLEAR,
      SC_COPY,
      SC_FILL,
      SC_QUERY,
      SC_COMMIT
   } scmd_type;

   typedef struct packed {
      logic valid;
      scmd_type kind;
      logic [15:0] lo;
      logic [15:0] hi;
      logic [15:0] port;
   } store_req_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic hit;
      logic [15:0] added;
   } store_rsp_type;

   typedef struct packed {
      logic start;
      logic step;
      logic fin;
      logic close;
   } scan_ctl_type;

   typedef struct packed {
      phase_type phase;
      logic err;
      logic seen;
      logic split;
      logic seg_ok;
      logic [16:0] lo;
      logic [16:0] hi;
   } scan_stat_type;

endpackage

>>> rtl/port_list_expression_parser_core.sv
// ----------------------------------------------------------------------------
// Port list expression parser core
// Parses comma-separated port and port-range expressions one character per
// transaction into a draft port bitmap and commits it when error free.
// ----------------------------------------------------------------------------
// After reset the committed map is cleared by a pass over all 8192 map bytes,
// during which no transaction is taken. The first character of an expression
// first clears or copies the draft map, one map byte per cycle. Each finished
// port or range reads, merges and writes back every map byte it covers (eight
// ports per byte) through one memory port. Commit swaps the two map banks.
// One result can wait in the output register; a second result stalls the core
// until the first is taken.
module port_list_expression_parser_core
   import plep_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   input req_type req_data,
   output logic rsp_valid,
   input logic rsp_ready,
   output rsp_type rsp_data
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_SWEEP,
      S_CHAR,
      S_FILL_WAIT,
      S_ENDCHK,
      S_DECIDE,
      S_QWAIT,
      S_RESULT
   } state_type;

   state_type state_ff;
   req_type item_ff;
   rsp_type res_ff;
   rsp_type rsp_data_ff;
   logic rsp_valid_ff;
   logic end_ff;
   logic [15:0] committed_total_ff;
   logic [15:0] draft_total_ff;

   scan_ctl_type sc_ctl;
   scan_stat_type sc_stat;
   store_req_type st_req;
   store_rsp_type st_rsp;

   logic item_end;
   logic expr_ok;

   plep_scan u_scan (
      .clock(clock),
      .reset(reset),
      .ctl(sc_ctl),
      .ch(item_ff.ch),
      .stat(sc_stat)
   );

   plep_store u_store (
      .clock(clock),
      .reset(reset),
      .req(st_req),
      .rsp(st_rsp)
   );

   assign item_end = (item_ff.ch == CH_NUL) || item_ff.last;
   assign expr_ok = !sc_stat.err && sc_stat.seen;
   assign req_ready = (state_ff == S_IDLE) && !st_rsp.busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   always_comb begin
      sc_ctl = '0;
      st_req = '0;
      st_req.lo = sc_stat.lo[15:0];
      st_req.hi = sc_stat.hi[15:0];
      st_req.port = item_ff.port;
      unique case (state_ff)
         S_DISPATCH: begin
            if (item_ff.op == OP_QUERY) begin
               st_req.valid = 1'b1;
               st_req.kind = SC_QUERY;
            end else if (sc_stat.phase == PH_IDLE) begin
               st_req.valid = 1'b1;
               st_req.kind = (item_ff.op == OP_EXTEND) ? SC_COPY : SC_CLEAR;
               sc_ctl.start = 1'b1;
            end
         end
         S_CHAR: begin
            if (item_ff.ch == CH_SEP) begin
               if (sc_stat.split) begin
                  sc_ctl.fin = 1'b1;
                  st_req.valid = sc_stat.seg_ok;
                  st_req.kind = SC_FILL;
               end
            end else if (item_ff.ch != CH_NUL) begin
               sc_ctl.step = 1'b1;
            end
         end
         S_ENDCHK: begin
            if (item_end && sc_stat.split) begin
               sc_ctl.fin = 1'b1;
               st_req.valid = sc_stat.seg_ok;
               st_req.kind = SC_FILL;
            end
         end
         S_DECIDE: begin
            sc_ctl.close = 1'b1;
            st_req.valid = expr_ok;
            st_req.kind = SC_COMMIT;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         committed_total_ff <= '0;
         draft_total_ff <= '0;
         end_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && state_ff != S_RESULT) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid && req_ready) begin
                  item_ff <= req_data;
                  end_ff <= 1'b0;
                  if (req_data.op != OP_NONE) begin
                     state_ff <= S_DISPATCH;
                  end
               end
            end
            S_DISPATCH: begin
               if (item_ff.op == OP_QUERY) begin
                  state_ff <= S_QWAIT;
               end else if (sc_stat.phase == PH_IDLE) begin
                  draft_total_ff <= (item_ff.op == OP_EXTEND) ? committed_total_ff : '0;
                  state_ff <= S_SWEEP;
               end else begin
                  state_ff <= S_CHAR;
               end
            end
            S_SWEEP: begin
               if (st_rsp.done) begin
                  state_ff <= S_CHAR;
               end
            end
            S_CHAR: begin
               if (item_ff.ch == CH_SEP && sc_stat.split && sc_stat.seg_ok) begin
                  state_ff <= S_FILL_WAIT;
               end else begin
                  state_ff <= S_ENDCHK;
               end
            end
            S_FILL_WAIT: begin
               if (st_rsp.done) begin
                  draft_total_ff <= draft_total_ff + st_rsp.added;
                  state_ff <= end_ff ? S_DECIDE : S_ENDCHK;
               end
            end
            S_ENDCHK: begin
               if (!item_end) begin
                  state_ff <= S_IDLE;
               end else if (sc_stat.split && sc_stat.seg_ok) begin
                  end_ff <= 1'b1;
                  state_ff <= S_FILL_WAIT;
               end else begin
                  state_ff <= S_DECIDE;
               end
            end
            S_DECIDE: begin
               if (expr_ok) begin
                  committed_total_ff <= draft_total_ff;
               end
               res_ff.kind <= KIND_DONE;
               res_ff.ok <= expr_ok;
               res_ff.count <= expr_ok ? draft_total_ff : committed_total_ff;
               res_ff.hit <= 1'b0;
               state_ff <= S_RESULT;
            end
            S_QWAIT: begin
               if (st_rsp.done) begin
                  res_ff.kind <= KIND_QUERY;
                  res_ff.ok <= 1'b0;
                  res_ff.count <= committed_total_ff;
                  res_ff.hit <= st_rsp.hit;
                  state_ff <= S_RESULT;
               end
            end
            S_RESULT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_data_ff <= res_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

`ifndef NO_ASSERTIONS
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.op != OP_NONE) |=> !req_ready)
      else $error("Second transaction accepted while an item is in work.");

   a_total_at_decide: assert property (@(posedge clock) disable iff (reset)
      !$stable(committed_total_ff) |-> $past(state_ff == S_DECIDE))
      else $error("Committed total changed outside an expression decision.");

   a_done_expected: assert property (@(posedge clock) disable iff (reset)
      st_rsp.done |-> (state_ff == S_SWEEP || state_ff == S_FILL_WAIT
                       || state_ff == S_QWAIT))
      else $error("Map store finished a command nobody waits for.");
`endif

endmodule

>>> rtl/plep_scan.sv
// ----------------------------------------------------------------------------
// Port list expression scanner
// Character-level parse state: phase, number accumulators and error flags.
// ----------------------------------------------------------------------------
module plep_scan
   import plep_pkg::*;
(
   input logic clock,
   input logic reset,
   input scan_ctl_type ctl,
   input logic [7:0] ch,
   output scan_stat_type stat
);

   phase_type phase_ff, phase_in;
   logic [16:0] first_ff, first_in;
   logic [16:0] cur_ff, cur_in;
   logic err_ff, err_in;
   logic dash_ff, dash_in;
   logic seen_ff, seen_in;

   logic [19:0] acc;
   logic [16:0] acc_sat;
   logic is_space;
   logic is_digit;
   logic lead_ok;
   logic [16:0] lo;

   assign is_space = (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
   assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
   assign lead_ok = (phase_ff == PH_SEG_EMPTY) || (phase_ff == PH_LEAD);
   assign acc = 20'(cur_ff) * RADIX + 20'(ch - CH_ZERO);
   assign acc_sat = (acc > 20'(PORT_LIMIT)) ? PORT_LIMIT : acc[16:0];
   assign lo = dash_ff ? first_ff : cur_ff;

   assign stat.phase = phase_ff;
   assign stat.err = err_ff;
   assign stat.seen = seen_ff;
   assign stat.lo = lo;
   assign stat.hi = cur_ff;
   assign stat.split = !err_ff && (phase_ff != PH_SEG_EMPTY);
   assign stat.seg_ok = (phase_ff == PH_DIGITS) && (lo != '0) && (cur_ff != '0)
      && (lo < PORT_LIMIT) && (cur_ff < PORT_LIMIT) && (cur_ff >= lo);

   always_comb begin
      phase_in = phase_ff;
      first_in = first_ff;
      cur_in = cur_ff;
      err_in = err_ff;
      dash_in = dash_ff;
      seen_in = seen_ff;
      if (ctl.start || ctl.close) begin
         phase_in = ctl.start ? PH_SEG_EMPTY : PH_IDLE;
         first_in = '0;
         cur_in = '0;
         err_in = 1'b0;
         dash_in = 1'b0;
         seen_in = 1'b0;
      end else if (ctl.fin) begin
         if (stat.seg_ok) begin
            phase_in = PH_SEG_EMPTY;
            first_in = '0;
            cur_in = '0;
            dash_in = 1'b0;
         end else begin
            err_in = 1'b1;
         end
      end else if (ctl.step && !err_ff && ch != CH_SEP) begin
         if (phase_ff == PH_SEG_EMPTY) begin
            seen_in = 1'b1;
         end
         if (ch == CH_DASH) begin
            if (dash_ff || phase_ff != PH_DIGITS) begin
               err_in = 1'b1;
            end else begin
               first_in = cur_ff;
               cur_in = '0;
               dash_in = 1'b1;
               phase_in = PH_LEAD;
            end
         end else if (is_space) begin
            if (lead_ok) begin
               phase_in = PH_LEAD;
            end else begin
               err_in = 1'b1;
            end
         end else if (ch == CH_PLUS) begin
            if (lead_ok) begin
               phase_in = PH_SIGN;
            end else begin
               err_in = 1'b1;
            end
         end else if (is_digit) begin
            cur_in = acc_sat;
            phase_in = PH_DIGITS;
         end else begin
            err_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         first_ff <= '0;
         cur_ff <= '0;
         err_ff <= 1'b0;
         dash_ff <= 1'b0;
         seen_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         first_ff <= first_in;
         cur_ff <= cur_in;
         err_ff <= err_in;
         dash_ff <= dash_in;
         seen_ff <= seen_in;
      end
   end

endmodule

>>> rtl/plep_store.sv
// ----------------------------------------------------------------------------
// Port list expression map store
// Two banked port bitmaps: one committed, one draft. Commit swaps the banks;
// clear, copy and range fill sweep the draft bank one byte at a time.
// ----------------------------------------------------------------------------
module plep_store
   import plep_pkg::*;
(
   input logic clock,
   input logic reset,
   input store_req_type req,
   output store_rsp_type rsp
);

   typedef enum logic [2:0] {
      ST_RESET_CLR,
      ST_IDLE,
      ST_CLEAR,
      ST_COPY,
      ST_FILL_RD,
      ST_FILL_WR,
      ST_QUERY
   } state_type;

   state_type state_ff;
   logic [MAP_AW:0] cnt_ff;
   logic [15:0] lo_ff;
   logic [15:0] hi_ff;
   logic [15:0] port_ff;
   logic sel_ff;
   logic [15:0] added_ff;

   logic [7:0] mem0 [MAP_DEPTH];
   logic [7:0] mem1 [MAP_DEPTH];
   logic [7:0] rd0_ff;
   logic [7:0] rd1_ff;

   logic cw_en, dw_en, cr_en, dr_en;
   logic [MAP_AW-1:0] cw_addr, dw_addr, cr_addr, dr_addr;
   logic [7:0] dw_data;
   logic we0, we1, re0, re1;
   logic [MAP_AW-1:0] wa0, wa1, ra0, ra1;
   logic [7:0] wd0, wd1;
   logic [7:0] rd_commit, rd_draft;

   logic [MAP_AW-1:0] addr;
   logic [MAP_AW-1:0] addr_m1;
   logic last_byte;
   logic [7:0] lo_mask, hi_mask, fill_mask, new_bits;
   logic [15:0] added_nx;
   logic sweep_end;
   logic copy_end;

   assign addr = cnt_ff[MAP_AW-1:0];
   assign addr_m1 = MAP_AW'(cnt_ff - 1'b1);
   assign last_byte = (addr == hi_ff[15:3]);
   assign sweep_end = (cnt_ff == (MAP_AW+1)'(MAP_DEPTH - 1));
   assign copy_end = (cnt_ff == (MAP_AW+1)'(MAP_DEPTH));

   assign rd_commit = sel_ff ? rd1_ff : rd0_ff;
   assign rd_draft = sel_ff ? rd0_ff : rd1_ff;

   assign lo_mask = (addr == lo_ff[15:3]) ? (8'hFF << lo_ff[2:0]) : 8'hFF;
   assign hi_mask = last_byte ? (8'hFF >> (BIT_MASK - hi_ff[2:0])) : 8'hFF;
   assign fill_mask = lo_mask & hi_mask;
   assign new_bits = fill_mask & ~rd_draft;
   assign added_nx = added_ff + 16'($countones(new_bits));

   always_comb begin
      cw_en = 1'b0;
      cw_addr = addr;
      dw_en = 1'b0;
      dw_addr = addr;
      dw_data = '0;
      cr_en = 1'b0;
      cr_addr = addr;
      dr_en = 1'b0;
      dr_addr = addr;
      unique case (state_ff)
         ST_RESET_CLR: begin
            cw_en = 1'b1;
         end
         ST_IDLE: begin
            if (req.valid && req.kind == SC_QUERY) begin
               cr_en = 1'b1;
               cr_addr = req.port[15:3];
            end
         end
         ST_CLEAR: begin
            dw_en = 1'b1;
         end
         ST_COPY: begin
            cr_en = !copy_end;
            dw_en = (cnt_ff != '0);
            dw_addr = addr_m1;
            dw_data = rd_commit;
         end
         ST_FILL_RD: begin
            dr_en = 1'b1;
         end
         ST_FILL_WR: begin
            dw_en = 1'b1;
            dw_data = rd_draft | fill_mask;
         end
         ST_QUERY: begin
         end
         default: begin
         end
      endcase
   end

   assign we0 = sel_ff ? dw_en : cw_en;
   assign wa0 = sel_ff ? dw_addr : cw_addr;
   assign wd0 = sel_ff ? dw_data : '0;
   assign re0 = sel_ff ? dr_en : cr_en;
   assign ra0 = sel_ff ? dr_addr : cr_addr;
   assign we1 = sel_ff ? cw_en : dw_en;
   assign wa1 = sel_ff ? cw_addr : dw_addr;
   assign wd1 = sel_ff ? '0 : dw_data;
   assign re1 = sel_ff ? cr_en : dr_en;
   assign ra1 = sel_ff ? cr_addr : dr_addr;

   always_ff @(posedge clock) begin
      if (we0) begin
         mem0[wa0] <= wd0;
      end
      if (re0) begin
         rd0_ff <= mem0[ra0];
      end
   end

   always_ff @(posedge clock) begin
      if (we1) begin
         mem1[wa1] <= wd1;
      end
      if (re1) begin
         rd1_ff <= mem1[ra1];
      end
   end

   assign rsp.busy = (state_ff != ST_IDLE);
   assign rsp.done = ((state_ff == ST_CLEAR) && sweep_end)
      || ((state_ff == ST_COPY) && copy_end)
      || ((state_ff == ST_FILL_WR) && last_byte)
      || (state_ff == ST_QUERY);
   assign rsp.hit = (state_ff == ST_QUERY) && rd_commit[port_ff[2:0]]
      && (port_ff != '0) && (17'(port_ff) < PORT_LIMIT);
   assign rsp.added = added_nx;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RESET_CLR;
         cnt_ff <= '0;
         sel_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_RESET_CLR: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (sweep_end) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               cnt_ff <= (req.valid && req.kind == SC_FILL) ? {1'b0, req.lo[15:3]} : '0;
               if (req.valid) begin
                  lo_ff <= req.lo;
                  hi_ff <= req.hi;
                  port_ff <= req.port;
                  added_ff <= '0;
                  unique case (req.kind)
                     SC_CLEAR: state_ff <= ST_CLEAR;
                     SC_COPY: state_ff <= ST_COPY;
                     SC_FILL: state_ff <= ST_FILL_RD;
                     SC_QUERY: state_ff <= ST_QUERY;
                     SC_COMMIT: sel_ff <= !sel_ff;
                     default: state_ff <= ST_IDLE;
                  endcase
               end
            end
            ST_CLEAR: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (sweep_end) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_COPY: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (copy_end) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_FILL_RD: begin
               state_ff <= ST_FILL_WR;
            end
            ST_FILL_WR: begin
               added_ff <= added_nx;
               cnt_ff <= cnt_ff + 1'b1;
               state_ff <= last_byte ? ST_IDLE : ST_FILL_RD;
            end
            ST_QUERY: begin
               state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

>>> sim/tb_port_list_expression_parser_core.sv
// ----------------------------------------------------------------------------
// Port list expression parser core testbench
// Sends port list expressions and membership queries one transaction at a
// time under random idle gaps and response stalls. An internal bitmap model
// predicts every response, which is checked field by field in order.
// ----------------------------------------------------------------------------
module tb_port_list_expression_parser_core;
   import plep_pkg::*;

   typedef struct {
      req_type data;
      bit drain;
      bit hold_rx;
   } stim_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   req_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   rsp_type rsp_data;

   stim_type pending[$];
   rsp_type expected_rsp[$];

   bit committed_bits[65536];
   bit draft_bits[65536];
   int unsigned committed_total;
   int unsigned draft_total;
   phase_type phase;
   logic [16:0] first_value;
   logic [16:0] current_value;
   bit err_flag;
   bit dash_flag;
   bit seen_flag;

   int errors;
   int num_ok;
   int num_rejected;
   int num_hits;
   int num_queries;
   int num_items;
   int gap_left;
   int hold_left;
   int hold_trig;
   int hold_seen;
   bit burst;
   bit req_taken;
   bit pressure_done;

   port_list_expression_parser_core u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task automatic report(string what, int got, int want);
      $display("mismatch in %s: got %0d, expected %0d", what, got, want);
      errors++;
   endtask

   function automatic void close_segment();
      logic [16:0] lo;
      logic [16:0] hi;
      if (phase != PH_DIGITS) begin
         err_flag = 1;
         return;
      end
      hi = current_value;
      lo = dash_flag ? first_value : hi;
      if (lo == 0 || hi == 0 || lo >= PORT_LIMIT || hi >= PORT_LIMIT || hi < lo) begin
         err_flag = 1;
         return;
      end
      for (int p = lo; p <= hi; p++) begin
         if (!draft_bits[p]) begin
            draft_bits[p] = 1;
            draft_total = (draft_total + 1) & 16'hFFFF;
         end
      end
      dash_flag = 0;
      current_value = '0;
      first_value = '0;
      phase = PH_SEG_EMPTY;
   endfunction

   function automatic void parse_char(logic [7:0] c);
      int unsigned v;
      if (err_flag) return;
      if (c == CH_SEP) begin
         if (phase != PH_SEG_EMPTY) close_segment();
         return;
      end
      if (phase == PH_SEG_EMPTY) seen_flag = 1;
      if (c == CH_DASH) begin
         if (dash_flag || phase != PH_DIGITS) begin
            err_flag = 1;
            return;
         end
         first_value = current_value;
         current_value = '0;
         dash_flag = 1;
         phase = PH_LEAD;
      end else if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
         if (phase == PH_SEG_EMPTY || phase == PH_LEAD) phase = PH_LEAD;
         else err_flag = 1;
      end else if (c == CH_PLUS) begin
         if (phase == PH_SEG_EMPTY || phase == PH_LEAD) phase = PH_SIGN;
         else err_flag = 1;
      end else if (c >= CH_ZERO && c <= CH_NINE) begin
         v = current_value * 10 + (c - CH_ZERO);
         if (v > PORT_LIMIT) v = PORT_LIMIT;
         current_value = 17'(v);
         phase = PH_DIGITS;
      end else begin
         err_flag = 1;
      end
   endfunction

   function automatic bit predict_parser(req_type r, output rsp_type res);
      bit accepted;
      res = '0;
      if (r.op == OP_QUERY) begin
         res.kind = KIND_QUERY;
         res.count = 16'(committed_total);
         res.hit = committed_bits[r.port];
         num_queries++;
         if (res.hit) num_hits++;
         return 1;
      end
      if (r.op == OP_NONE) return 0;
      if (phase == PH_IDLE) begin
         if (r.op == OP_EXTEND) begin
            draft_bits = committed_bits;
            draft_total = committed_total;
         end else begin
            foreach (draft_bits[i]) draft_bits[i] = 0;
            draft_total = 0;
         end
         first_value = '0;
         current_value = '0;
         err_flag = 0;
         dash_flag = 0;
         seen_flag = 0;
         phase = PH_SEG_EMPTY;
      end
      if (r.ch != CH_NUL) parse_char(r.ch);
      if (r.ch != CH_NUL && !r.last) return 0;
      if (!err_flag && phase != PH_SEG_EMPTY) close_segment();
      accepted = !err_flag && seen_flag;
      if (accepted) begin
         committed_bits = draft_bits;
         committed_total = draft_total & 16'hFFFF;
         num_ok++;
      end else begin
         num_rejected++;
      end
      phase = PH_IDLE;
      first_value = '0;
      current_value = '0;
      err_flag = 0;
      dash_flag = 0;
      seen_flag = 0;
      res.kind = KIND_DONE;
      res.ok = accepted;
      res.count = 16'(committed_total);
      return 1;
   endfunction

   // Prediction runs before the check so that both see the same edge.
   always @(posedge clock) begin
      rsp_type want;
      req_taken = req_valid && req_ready && !reset;
      if (req_taken) begin
         if (predict_parser(req_data, want)) expected_rsp.push_back(want);
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp.size() == 0) begin
            report("unexpected response", 1, 0);
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_data.kind !== want.kind) report("kind", rsp_data.kind, want.kind);
            if (rsp_data.ok !== want.ok) report("ok", rsp_data.ok, want.ok);
            if (rsp_data.count !== want.count) report("count", rsp_data.count, want.count);
            if (rsp_data.hit !== want.hit) report("hit", rsp_data.hit, want.hit);
         end
      end
   end

   function automatic int pick_gap();
      int r;
      if ($urandom_range(0, 63) == 0) burst = !burst;
      if (burst) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 20);
      return $urandom_range(50, 200);
   endfunction

   always @(negedge clock) begin
      logic next_valid;
      req_type next_data;
      stim_type it;
      next_valid = req_valid;
      next_data = req_data;
      if (reset) begin
         next_valid = 1'b0;
      end else if (!req_valid || req_taken) begin
         next_valid = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (pending.size() > 0 &&
                      !(pending[0].drain && expected_rsp.size() > 0)) begin
            it = pending.pop_front();
            next_valid = 1'b1;
            next_data = it.data;
            if (it.hold_rx) hold_trig++;
            gap_left = pick_gap();
         end
      end
      req_valid <= next_valid;
      req_data <= next_data;
   end

   always @(negedge clock) begin
      logic next_ready;
      if (hold_left > 0) begin
         hold_left--;
         next_ready = 1'b0;
      end else if (hold_trig != hold_seen) begin
         hold_seen = hold_trig;
         hold_left = 400;
         next_ready = 1'b0;
      end else begin
         next_ready = (pick_gap() == 0);
      end
      rsp_ready <= reset ? 1'b0 : next_ready;
   end

   task automatic add_item(logic [1:0] op, logic [7:0] ch, bit last,
                           logic [15:0] port, bit drain = 0, bit hold_rx = 0);
      stim_type it;
      it.data.op = op;
      it.data.ch = ch;
      it.data.last = last;
      it.data.port = port;
      it.drain = drain;
      it.hold_rx = hold_rx;
      pending.push_back(it);
      num_items++;
   endtask

   task automatic add_query(logic [15:0] port, bit drain = 0, bit hold_rx = 0);
      add_item(OP_QUERY, 8'($urandom), 1'($urandom_range(0, 1)), port, drain, hold_rx);
   endtask

   // Sends one expression; it ends on a NUL transaction when nul_end is set or the string is empty.
   task automatic add_expr(string s, logic [1:0] mode, bit nul_end, bit noisy = 0);
      logic [1:0] op;
      for (int i = 0; i < s.len(); i++) begin
         op = (i == 0) ? mode : 2'($urandom_range(0, 1));
         add_item(op, s[i], !nul_end && i == s.len() - 1, 16'($urandom));
         if (noisy && $urandom_range(0, 9) == 0) add_query(16'($urandom_range(1, 3000)));
         if (noisy && $urandom_range(0, 39) == 0)
            add_item(OP_NONE, 8'($urandom), 1'($urandom_range(0, 1)), 16'($urandom));
      end
      if (nul_end || s.len() == 0)
         add_item(mode, CH_NUL, 1'($urandom_range(0, 1)), 16'($urandom));
   endtask

   function automatic string random_expr();
      string s;
      int lo;
      int r;
      s = "";
      for (int n = $urandom_range(1, 4); n > 0; n--) begin
         if (s.len() > 0) s = {s, ","};
         if ($urandom_range(0, 9) == 0) s = {s, ","};
         r = $urandom_range(0, 9);
         if (r == 0) s = {s, " "};
         else if (r == 1) s = {s, "\t+"};
         else if (r == 2) s = {s, "+"};
         r = $urandom_range(0, 99);
         lo = $urandom_range(1, 3000);
         if (r < 45) s = {s, $sformatf("%0d", lo)};
         else if (r < 88) s = {s, $sformatf("%0d-%0d", lo, lo + $urandom_range(0, 60))};
         else if (r < 96) s = {s, $sformatf("%0d", $urandom_range(1, 65535))};
         else if (r < 99) s = {s, $sformatf("%0d-%0d", lo, lo + $urandom_range(0, 3000))};
         else s = {s, "1-65535"};
      end
      if ($urandom_range(0, 6) == 0) s[$urandom_range(0, s.len() - 1)] = 8'($urandom);
      return s;
   endfunction

   initial begin
      errors = 0;
      num_ok = 0;
      num_rejected = 0;
      num_hits = 0;
      num_queries = 0;
      num_items = 0;
      gap_left = 0;
      hold_left = 0;
      hold_trig = 0;
      hold_seen = 0;
      burst = 0;
      req_taken = 0;
      pressure_done = 0;
      committed_total = 0;
      draft_total = 0;
      phase = PH_IDLE;
      first_value = '0;
      current_value = '0;
      err_flag = 0;
      dash_flag = 0;
      seen_flag = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;

      add_expr("1,65535,+7", OP_REPLACE, 0);
      add_query(16'd0);
      add_query(16'd65535);
      add_expr(" 10-12", OP_EXTEND, 1);
      add_query(16'd11);
      add_expr("65536", OP_REPLACE, 0);
      add_expr("0", OP_REPLACE, 0);
      add_expr("", OP_REPLACE, 1);
      add_expr("9 ", OP_REPLACE, 0);
      add_expr("5-3", OP_REPLACE, 0);
      add_expr("1-2-3", OP_REPLACE, 0);
      add_expr("-4", OP_REPLACE, 0);
      add_expr("4-", OP_REPLACE, 0);
      add_expr("++5", OP_REPLACE, 0);
      add_expr("99999999", OP_REPLACE, 0);
      add_expr(",,3,,", OP_REPLACE, 0, 1);
      add_item(OP_NONE, 8'hFF, 1'b1, 16'hFFFF);
      add_expr("x", OP_REPLACE, 0);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (num_items < 1000) begin
         if (!pressure_done && num_items > 400) begin
            add_query(16'($urandom_range(1, 3000)), 0, 1);
            repeat (20) add_query(16'($urandom_range(1, 3000)));
            add_query(16'($urandom_range(1, 3000)), 1, 0);
            pressure_done = 1;
         end
         if ($urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 6))
               add_query($urandom_range(0, 1) ? 16'($urandom_range(1, 3000))
                                              : 16'($urandom));
         end else begin
            add_expr(random_expr(), 2'($urandom_range(0, 1)),
                     $urandom_range(0, 4) == 0, 1);
         end
         while (pending.size() > 50) @(posedge clock);
      end

      while (pending.size() > 0 || req_valid || expected_rsp.size() > 0) @(posedge clock);
      repeat (64) @(posedge clock);
      $display("covered %0d queries (%0d hits), %0d accepted and %0d rejected expressions",
               num_queries, num_hits, num_ok, num_rejected);
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #40000000;
      $display("simulation failed");
      $finish;
   end

endmodule
